FILE: rtl/core/rrqs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rrqs_pkg;

  localparam int unsigned AGENT_SLOTS_DEF = 16;
  localparam int unsigned QUANTUM_W = 12;

  typedef enum logic [1:0] {
    OP_TICK      = 2'd0,
    OP_ADD       = 2'd1,
    OP_YIELD     = 2'd2,
    OP_SET_READY = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_ABSENT = 2'd2
  } status_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] agent_priority;
    logic [3:0] agent_index;
    logic       ready_value;
  } req_item_t;

  typedef struct packed {
    logic [3:0] active_agent;
    logic [4:0] agent_total;
    logic [3:0] new_agent_id;
    status_e    status;
    logic       switched;
  } rsp_item_t;

  // Outcome of one round-robin walk over the ready flags.
  typedef struct packed {
    logic done;
    logic found;
  } walk_rsp_t;

  // Ten times the priority, built from two shifts.
  function automatic logic [QUANTUM_W-1:0] quantum_of(input logic [7:0] prio);
    logic [QUANTUM_W-1:0] p;
    p = QUANTUM_W'(prio);
    return (p << 3) + (p << 1);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/rrqs_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface rrqs_req_if;
  import rrqs_pkg::*;

  logic      valid;
  logic      ready;
  req_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rrqs_rsp_if;
  import rrqs_pkg::*;

  logic      valid;
  logic      ready;
  rsp_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/round_robin_quantum_scheduler_top.sv
// Round-robin time-slice scheduler over a table of agents.
// Requests arrive on req_i (valid/ready); each accepted transaction is a
// tick, an add, a yield or a ready-flag write. Exactly one result leaves on
// rsp_o per request, in order, carrying the running agent, the agent count,
// the id given by an add, a status code and a switched flag.
// One request is processed at a time; req_i is ready only while idle.
// Add, set-ready and ticks that cause no switch go from the execute state
// straight to the result state, which loads the result register and
// returns to idle for the next request. A yield, or a tick whose quantum
// expires, walks the ready flags one slot per cycle starting after the
// running agent, examining at most N slots for N agents in the table,
// before the result state loads the result register; the walk and its
// single memory read port make such requests the slower ones.
// A finished result waits in the output register while rsp_o is stalled;
// the next request may be accepted and processed meanwhile, and its result
// is held back until the register is free.
// Reset empties the table and makes agent 0 the running agent. Table
// entries are meaningful only once their agent has been added.
`timescale 1ns / 1ps
`default_nettype none

module round_robin_quantum_scheduler_top #(
  parameter int unsigned AGENT_SLOTS = rrqs_pkg::AGENT_SLOTS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rrqs_req_if.sink   req_i,
  rrqs_rsp_if.source rsp_o
);
  import rrqs_pkg::*;

  localparam int unsigned IDX_W = (AGENT_SLOTS > 1) ? $clog2(AGENT_SLOTS) : 1;
  localparam int unsigned CNT_W = $clog2(AGENT_SLOTS + 1);
  localparam int unsigned CW    = CNT_W + 4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_WALK,
    S_RESULT
  } state_e;

  state_e           state_q;
  req_item_t        item_q;
  logic [CNT_W-1:0] total_q;
  logic [IDX_W-1:0] running_q;
  rsp_item_t        res_q;
  logic             rsp_valid_q;
  rsp_item_t        rsp_q;

  logic [7:0]           prio_mem  [AGENT_SLOTS];
  logic [QUANTUM_W-1:0] quant_mem [AGENT_SLOTS];
  logic                 ready_mem [AGENT_SLOTS];
  logic [7:0]           prio_rd_q;
  logic [QUANTUM_W-1:0] quant_rd_q;
  logic                 ready_rd_q;

  logic                 table_full;
  logic                 index_absent;
  logic [IDX_W-1:0]     total_idx;
  logic [IDX_W-1:0]     index_idx;
  logic [QUANTUM_W-1:0] quant_dec;
  logic [IDX_W+3:0]     running_ext;
  logic [CNT_W+4:0]     total_ext;
  logic [IDX_W+3:0]     total_idx_ext;
  logic [IDX_W+3:0]     index_ext;

  logic                 mem_add_we;
  logic                 ready_we;
  logic                 ready_wdata;
  logic                 quant_we;
  logic [QUANTUM_W-1:0] quant_wdata;
  logic [IDX_W-1:0]     mem_waddr;
  logic                 walk_start;
  rsp_item_t            exec_res;

  logic [IDX_W-1:0] walk_addr;
  walk_rsp_t        walk_rsp;
  logic [IDX_W-1:0] walk_idx;

  logic accept;
  logic out_free;
  logic rsp_load;

  assign accept   = req_i.valid && req_i.ready;
  assign out_free = !rsp_valid_q || rsp_o.ready;
  assign rsp_load = (state_q == S_RESULT) && out_free;

  assign req_i.ready = (state_q == S_IDLE);
  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_q;

  assign table_full    = (total_q == CNT_W'(AGENT_SLOTS));
  assign index_absent  = CW'(item_q.agent_index) >= CW'(total_q);
  assign total_idx     = total_q[IDX_W-1:0];
  assign index_ext     = (IDX_W + 4)'(item_q.agent_index);
  assign index_idx     = index_ext[IDX_W-1:0];
  assign quant_dec     = quant_rd_q - QUANTUM_W'(1);
  assign running_ext   = (IDX_W + 4)'(running_q);
  assign total_ext     = (CNT_W + 5)'(total_q);
  assign total_idx_ext = (IDX_W + 4)'(total_idx);

  // Table write controls and the status of the request being executed.
  always_comb begin
    mem_add_we  = 1'b0;
    ready_we    = 1'b0;
    ready_wdata = 1'b1;
    quant_we    = 1'b0;
    quant_wdata = quantum_of(item_q.agent_priority);
    mem_waddr   = running_q;
    walk_start  = 1'b0;
    exec_res    = '0;
    if (state_q == S_EXEC) begin
      unique case (item_q.op)
        OP_ADD: begin
          mem_waddr = total_idx;
          if (!table_full) begin
            mem_add_we            = 1'b1;
            ready_we              = 1'b1;
            quant_we              = 1'b1;
            exec_res.new_agent_id = total_idx_ext[3:0];
          end else begin
            exec_res.status = STAT_FULL;
          end
        end
        OP_SET_READY: begin
          mem_waddr   = index_idx;
          ready_wdata = item_q.ready_value;
          ready_we    = !index_absent;
          if (index_absent) begin
            exec_res.status = STAT_ABSENT;
          end
        end
        OP_TICK: begin
          if (total_q != '0 && quant_rd_q != '0) begin
            quant_we = 1'b1;
            if (quant_dec != '0) begin
              quant_wdata = quant_dec;
            end else begin
              quant_wdata = quantum_of(prio_rd_q);
              walk_start  = 1'b1;
            end
          end
        end
        OP_YIELD: begin
          walk_start = (total_q != '0);
        end
        default: begin
          walk_start = 1'b0;
        end
      endcase
    end
  end

  // Agent tables. The running agent's priority and quantum are read every
  // cycle, so they are current by the time an accepted tick executes.
  always_ff @(posedge clk_i) begin
    if (mem_add_we) begin
      prio_mem[mem_waddr] <= item_q.agent_priority;
    end
    if (quant_we) begin
      quant_mem[mem_waddr] <= quant_wdata;
    end
    if (ready_we) begin
      ready_mem[mem_waddr] <= ready_wdata;
    end
    prio_rd_q  <= prio_mem[running_q];
    quant_rd_q <= quant_mem[running_q];
    ready_rd_q <= ready_mem[walk_addr];
  end

  rrqs_walker #(
    .AGENT_SLOTS (AGENT_SLOTS)
  ) u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (walk_start),
    .run_idx_i   (running_q),
    .total_i     (total_q),
    .ready_bit_i (ready_rd_q),
    .rd_addr_o   (walk_addr),
    .rsp_o       (walk_rsp),
    .found_idx_o (walk_idx)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      item_q      <= '0;
      total_q     <= '0;
      running_q   <= '0;
      res_q       <= '0;
      rsp_valid_q <= 1'b0;
      rsp_q       <= '0;
    end else begin
      if (rsp_load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            item_q  <= req_i.data;
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          res_q   <= exec_res;
          state_q <= walk_start ? S_WALK : S_RESULT;
          if (item_q.op == OP_ADD && !table_full) begin
            total_q <= total_q + CNT_W'(1);
          end
        end
        S_WALK: begin
          if (walk_rsp.done) begin
            state_q <= S_RESULT;
            if (walk_rsp.found && walk_idx != running_q) begin
              running_q      <= walk_idx;
              res_q.switched <= 1'b1;
            end
          end
        end
        S_RESULT: begin
          if (rsp_load) begin
            rsp_q   <= '{active_agent: running_ext[3:0],
                         agent_total:  total_ext[4:0],
                         new_agent_id: res_q.new_agent_id,
                         status:       res_q.status,
                         switched:     res_q.switched};
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  a_total_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CW'(total_q) <= CW'(AGENT_SLOTS))
    else $error("agent count exceeds the table size");

  a_running_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (total_q != '0) |-> (CW'(running_q) < CW'(total_q)))
    else $error("running agent lies outside the table");

  a_walk_hit_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (walk_rsp.done && walk_rsp.found) |-> (CW'(walk_idx) < CW'(total_q)))
    else $error("walk selected a slot beyond the table");

  a_accept_executes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_EXEC))
    else $error("accepted transaction was not executed");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && rsp_q.status == STAT_FULL) |-> table_full)
    else $error("table full reported with free slots");

endmodule

`default_nettype wire

FILE: rtl/core/rrqs_walker.sv
`timescale 1ns / 1ps
`default_nettype none

module rrqs_walker #(
  parameter int unsigned AGENT_SLOTS = rrqs_pkg::AGENT_SLOTS_DEF
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   start_i,
  input  wire logic [(AGENT_SLOTS > 1 ? $clog2(AGENT_SLOTS) : 1)-1:0] run_idx_i,
  input  wire logic [$clog2(AGENT_SLOTS + 1)-1:0]     total_i,
  input  wire logic                                   ready_bit_i,
  output logic [(AGENT_SLOTS > 1 ? $clog2(AGENT_SLOTS) : 1)-1:0]      rd_addr_o,
  output rrqs_pkg::walk_rsp_t                         rsp_o,
  output logic [(AGENT_SLOTS > 1 ? $clog2(AGENT_SLOTS) : 1)-1:0]      found_idx_o
);
  import rrqs_pkg::*;

  localparam int unsigned IDX_W = (AGENT_SLOTS > 1) ? $clog2(AGENT_SLOTS) : 1;
  localparam int unsigned CNT_W = $clog2(AGENT_SLOTS + 1);
  localparam int unsigned CW    = CNT_W + 1;

  logic             busy_q;
  logic [IDX_W-1:0] addr_q;
  logic [CNT_W-1:0] left_q;
  logic             chk_valid_q;
  logic [IDX_W-1:0] chk_addr_q;
  logic             chk_last_q;

  logic             hit;
  logic             miss;

  // Successor of an agent slot, wrapping at the agent count.
  function automatic logic [IDX_W-1:0] succ(input logic [IDX_W-1:0] a,
                                            input logic [CNT_W-1:0] n);
    logic [CW-1:0] inc;
    inc = CW'(a) + CW'(1);
    return (inc >= CW'(n)) ? '0 : inc[IDX_W-1:0];
  endfunction

  assign hit  = chk_valid_q && ready_bit_i;
  assign miss = chk_valid_q && !ready_bit_i && chk_last_q;

  assign rd_addr_o   = addr_q;
  assign rsp_o.done  = hit || miss;
  assign rsp_o.found = hit;
  assign found_idx_o = chk_addr_q;

  // The slot address goes out in one cycle and its ready flag is checked
  // in the next, so one slot is examined per cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      addr_q      <= '0;
      left_q      <= '0;
      chk_valid_q <= 1'b0;
      chk_addr_q  <= '0;
      chk_last_q  <= 1'b0;
    end else if (start_i) begin
      busy_q      <= 1'b1;
      addr_q      <= succ(run_idx_i, total_i);
      left_q      <= total_i;
      chk_valid_q <= 1'b0;
    end else if (hit || miss) begin
      busy_q      <= 1'b0;
      left_q      <= '0;
      chk_valid_q <= 1'b0;
    end else if (busy_q) begin
      chk_valid_q <= (left_q != '0);
      chk_addr_q  <= addr_q;
      chk_last_q  <= (left_q == CNT_W'(1));
      addr_q      <= succ(addr_q, total_i);
      if (left_q != '0) begin
        left_q <= left_q - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire
